// ===== rtl/mmlex_pkg.sv =====
// ----------------------------------------------------------------------------
// mmlex_pkg
// Shared types, character codes and token kinds for the longest-match lexer.
// ----------------------------------------------------------------------------
package mmlex_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned FIELD_W           = 16;
  localparam int unsigned MAX_TOKENS        = 3;

  // Operator characters
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Token kinds
  localparam logic [3:0] KIND_SEMI   = 4'd0;
  localparam logic [3:0] KIND_MINUS  = 4'd1;
  localparam logic [3:0] KIND_PLUS   = 4'd2;
  localparam logic [3:0] KIND_SLASH  = 4'd3;
  localparam logic [3:0] KIND_STAR   = 4'd4;
  localparam logic [3:0] KIND_EQUAL  = 4'd5;
  localparam logic [3:0] KIND_PERIOD = 4'd6;
  localparam logic [3:0] KIND_LPAREN = 4'd7;
  localparam logic [3:0] KIND_RPAREN = 4'd8;
  localparam logic [3:0] KIND_LBRACE = 4'd9;
  localparam logic [3:0] KIND_RBRACE = 4'd10;
  localparam logic [3:0] KIND_IDENT  = 4'd11;
  localparam logic [3:0] KIND_NUMBER = 4'd12;
  localparam logic [3:0] KIND_END    = 4'd13;
  localparam logic [3:0] KIND_ERROR  = 4'd14;

  // Class of the open run
  typedef enum logic [5:0] {
    RUN_NONE  = 6'b000001,
    RUN_IDENT = 6'b000010,
    RUN_SPACE = 6'b000100,
    RUN_INT   = 6'b001000,
    RUN_FRAC  = 6'b010000,
    RUN_DOT   = 6'b100000
  } run_class_t;

  typedef struct packed {
    logic       is_letter;
    logic       is_digit;
    logic       is_space;
    logic       is_dot;
    logic       is_op;
    logic [3:0] op_kind;
  } char_class_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
  } token_t;

  // Up to three tokens caused by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]   cnt;
    token_t [2:0] tok;
  } token_bundle_t;

  function automatic token_t make_tok(logic [3:0] kind, logic [FIELD_W-1:0] start,
                                      logic [FIELD_W-1:0] length);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    return t;
  endfunction

endpackage

// ===== rtl/mmlex_classify.sv =====
// ----------------------------------------------------------------------------
// mmlex_classify
// Byte decode: letter, digit, whitespace, period, operator and operator kind.
// ----------------------------------------------------------------------------
module mmlex_classify (
  input  logic [7:0]                char_byte,
  output mmlex_pkg::char_class_t    cls
);

  always_comb begin
    cls           = '0;
    cls.is_letter = char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    cls.is_digit  = char_byte inside {[8'h30:8'h39]};
    cls.is_space  = char_byte inside {8'h20, [8'h09:8'h0D]};
    cls.is_dot    = (char_byte == mmlex_pkg::CH_DOT);
    cls.is_op     = 1'b1;
    case (char_byte)
      mmlex_pkg::CH_SEMI:   cls.op_kind = mmlex_pkg::KIND_SEMI;
      mmlex_pkg::CH_MINUS:  cls.op_kind = mmlex_pkg::KIND_MINUS;
      mmlex_pkg::CH_PLUS:   cls.op_kind = mmlex_pkg::KIND_PLUS;
      mmlex_pkg::CH_SLASH:  cls.op_kind = mmlex_pkg::KIND_SLASH;
      mmlex_pkg::CH_STAR:   cls.op_kind = mmlex_pkg::KIND_STAR;
      mmlex_pkg::CH_EQUAL:  cls.op_kind = mmlex_pkg::KIND_EQUAL;
      mmlex_pkg::CH_LPAREN: cls.op_kind = mmlex_pkg::KIND_LPAREN;
      mmlex_pkg::CH_RPAREN: cls.op_kind = mmlex_pkg::KIND_RPAREN;
      mmlex_pkg::CH_LBRACE: cls.op_kind = mmlex_pkg::KIND_LBRACE;
      mmlex_pkg::CH_RBRACE: cls.op_kind = mmlex_pkg::KIND_RBRACE;
      default: begin
        // period opens a run of its own; it is not a direct operator here
        cls.is_op   = 1'b0;
        cls.op_kind = mmlex_pkg::KIND_ERROR;
      end
    endcase
  end

endmodule

// ===== rtl/mmlex_scan.sv =====
// ----------------------------------------------------------------------------
// mmlex_scan
// Open-run state and token generation for one byte.
// ----------------------------------------------------------------------------
module mmlex_scan #(
  parameter int unsigned POSITION_BITS = mmlex_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  mmlex_pkg::char_class_t     cc,
  input  logic                       last,
  output mmlex_pkg::token_bundle_t   bun
);

  localparam logic [POSITION_BITS-1:0] LEN_MAX = {POSITION_BITS{1'b1}};

  mmlex_pkg::run_class_t       run_r, run_nxt, cls;
  logic [POSITION_BITS-1:0]    start_r, start_nxt;
  logic [POSITION_BITS-1:0]    len_r, len_nxt;
  logic [POSITION_BITS-1:0]    pos_r, pos_nxt, pos_inc;
  logic                        disc_r, disc_nxt;
  logic                        ext, err;
  logic [1:0]                  n;

  function automatic logic has_run(mmlex_pkg::run_class_t rc);
    return (rc == mmlex_pkg::RUN_IDENT) || (rc == mmlex_pkg::RUN_INT) ||
           (rc == mmlex_pkg::RUN_FRAC) || (rc == mmlex_pkg::RUN_DOT);
  endfunction

  function automatic mmlex_pkg::token_t run_tok(mmlex_pkg::run_class_t rc,
                                                logic [POSITION_BITS-1:0] st,
                                                logic [POSITION_BITS-1:0] ln);
    mmlex_pkg::token_t t;
    case (rc)
      mmlex_pkg::RUN_IDENT:
        t = mmlex_pkg::make_tok(mmlex_pkg::KIND_IDENT, 16'(st), 16'(ln));
      mmlex_pkg::RUN_DOT:
        t = mmlex_pkg::make_tok(mmlex_pkg::KIND_PERIOD, 16'(st), 16'd1);
      default:
        t = mmlex_pkg::make_tok(mmlex_pkg::KIND_NUMBER, 16'(st), 16'(ln));
    endcase
    return t;
  endfunction

  assign pos_inc = pos_r + POSITION_BITS'(1);

  always_comb begin
    cls       = run_r;
    ext       = 1'b0;
    err       = 1'b0;
    n         = 2'd0;
    bun       = '0;
    run_nxt   = run_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_inc;
    disc_nxt  = disc_r;

    if (disc_r) begin
      // skipping the rest of a text after an error
      if (last) begin
        run_nxt   = mmlex_pkg::RUN_NONE;
        start_nxt = '0;
        len_nxt   = '0;
        pos_nxt   = '0;
        disc_nxt  = 1'b0;
      end
    end else begin
      case (run_r)
        mmlex_pkg::RUN_IDENT: ext = cc.is_letter | cc.is_digit;
        mmlex_pkg::RUN_SPACE: ext = cc.is_space;
        mmlex_pkg::RUN_INT: begin
          if (cc.is_dot) begin
            cls = mmlex_pkg::RUN_FRAC;
            ext = 1'b1;
          end else begin
            ext = cc.is_digit;
          end
        end
        mmlex_pkg::RUN_FRAC: ext = cc.is_digit;
        mmlex_pkg::RUN_DOT: begin
          if (cc.is_digit) begin
            cls = mmlex_pkg::RUN_FRAC;
            ext = 1'b1;
          end
        end
        default: ext = 1'b0;
      endcase

      if (ext) begin
        run_nxt = cls;
        if (len_r != LEN_MAX) begin
          len_nxt = len_r + POSITION_BITS'(1);
        end
      end else begin
        if (has_run(run_r)) begin
          bun.tok[n] = run_tok(run_r, start_r, len_r);
          n          = n + 2'd1;
        end
        start_nxt = pos_r;
        len_nxt   = POSITION_BITS'(1);
        if (cc.is_letter) begin
          run_nxt = mmlex_pkg::RUN_IDENT;
        end else if (cc.is_space) begin
          run_nxt = mmlex_pkg::RUN_SPACE;
        end else if (cc.is_digit) begin
          run_nxt = mmlex_pkg::RUN_INT;
        end else if (cc.is_dot) begin
          run_nxt = mmlex_pkg::RUN_DOT;
        end else begin
          run_nxt = mmlex_pkg::RUN_NONE;
          len_nxt = '0;
          if (cc.is_op) begin
            bun.tok[n] = mmlex_pkg::make_tok(cc.op_kind, 16'(pos_r), 16'd1);
          end else begin
            bun.tok[n] = mmlex_pkg::make_tok(mmlex_pkg::KIND_ERROR, 16'(pos_r), 16'd0);
            err        = 1'b1;
          end
          n = n + 2'd1;
        end
      end

      if (err) begin
        run_nxt = mmlex_pkg::RUN_NONE;
        len_nxt = '0;
        if (last) begin
          start_nxt = '0;
          pos_nxt   = '0;
        end else begin
          disc_nxt = 1'b1;
        end
      end else if (last) begin
        if (has_run(run_nxt)) begin
          bun.tok[n] = run_tok(run_nxt, start_nxt, len_nxt);
          n          = n + 2'd1;
        end
        bun.tok[n] = mmlex_pkg::make_tok(mmlex_pkg::KIND_END, 16'(pos_inc), 16'd0);
        n          = n + 2'd1;
        run_nxt    = mmlex_pkg::RUN_NONE;
        start_nxt  = '0;
        len_nxt    = '0;
        pos_nxt    = '0;
      end
    end
    bun.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= mmlex_pkg::RUN_NONE;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      disc_r  <= 1'b0;
    end else if (advance) begin
      run_r   <= run_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // every text ends with a clean slate
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last |=> pos_r == '0 && run_r == mmlex_pkg::RUN_NONE && !disc_r)
    else $error("text end did not clear scan state");

  // no tokens while skipping after an error
  a_disc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> bun.cnt == 2'd0)
    else $error("token produced while discarding");

endmodule

// ===== rtl/mmlex_outbuf.sv =====
// ----------------------------------------------------------------------------
// mmlex_outbuf
// Result register of up to three tokens, drained one per handshake.
// ----------------------------------------------------------------------------
module mmlex_outbuf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  mmlex_pkg::token_bundle_t   bun,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 out_token_kind,
  output logic [15:0]                out_start_position,
  output logic [15:0]                out_token_length,
  output logic                       out_last_of_run
);

  mmlex_pkg::token_t [2:0] slot_r;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    take, at_last;
  mmlex_pkg::token_t       cur;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign at_last   = ((idx_r + 2'd1) == cnt_r);
  assign free      = (cnt_r == 2'd0) || (take && at_last);

  always_comb begin
    case (idx_r)
      2'd0:    cur = slot_r[0];
      2'd1:    cur = slot_r[1];
      2'd2:    cur = slot_r[2];
      default: cur = slot_r[0];
    endcase
  end

  assign out_token_kind     = cur.kind;
  assign out_start_position = cur.start;
  assign out_token_length   = cur.length;
  assign out_last_of_run    = at_last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = bun.cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      if (at_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bun.tok;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd0 |-> idx_r < cnt_r)
    else $error("read index beyond loaded tokens");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("tokens loaded over undelivered ones");

  a_keep_pending: assert property (@(posedge clk) disable iff (!rst_n)
    take && !at_last |=> out_valid && idx_r == $past(idx_r) + 2'd1)
    else $error("pending token lost");

endmodule

// ===== rtl/maximal_munch_lexer_core.sv =====
// ----------------------------------------------------------------------------
// maximal_munch_lexer_core
// Longest-match lexer: bytes in, (kind, start, length) tokens out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and returns tokens in source
// order. A byte sits in an input register; the decode and run logic turns it into
// zero to three tokens held in a three-slot result register, which hands them
// out one per output handshake. Plain streams, in which each byte yields at
// most one token, run at one byte per clock while out_stall is low; a byte
// that closes a run and emits an operator or the end token yields two or three
// tokens, and a next byte with tokens stalls until the last one is handed out.
// Whitespace is dropped, identifiers and numbers are reported with start and
// length, a lone period becomes the period operator, and an unknown byte
// yields an error token after which bytes are dropped up to and including the
// one flagged end_of_text. Each text starts at offset 0; positions wrap and
// lengths saturate at POSITION_BITS bits, and the output fields carry the low
// 16 bits. Tokens reach the output through the input and result registers.
// ----------------------------------------------------------------------------
module maximal_munch_lexer_core #(
  parameter int unsigned POSITION_BITS = mmlex_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_text,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_start_position,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  // input register
  logic       hold_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic                      in_take;
  logic                      advance;
  logic                      buf_free;
  mmlex_pkg::char_class_t    cc;
  mmlex_pkg::token_bundle_t  bun;

  // A held byte moves on when the result register can take its tokens, or
  // right away if it produces none (whitespace, run extension, discard).
  assign advance  = hold_r && (buf_free || (bun.cnt == 2'd0));
  assign in_stall = hold_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_take) begin
      hold_r <= 1'b1;
    end else if (advance) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_char_byte;
      last_r <= in_end_of_text;
    end
  end

  mmlex_classify u_classify (
    .char_byte (byte_r),
    .cls       (cc)
  );

  mmlex_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cc      (cc),
    .last    (last_r),
    .bun     (bun)
  );

  mmlex_outbuf u_outbuf (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (advance && (bun.cnt != 2'd0)),
    .bun                (bun),
    .free               (buf_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_start_position (out_start_position),
    .out_token_length   (out_token_length),
    .out_last_of_run    (out_last_of_run)
  );

  // a byte that yields tokens never moves while undelivered tokens remain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    advance && bun.cnt != 2'd0 |-> buf_free)
    else $error("held byte advanced over pending tokens");

  // an item taken while another is held means the held one moved on
  a_hold_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && hold_r |-> advance)
    else $error("input register overwritten");

  // end of text closes with an end token of length zero unless an error came first
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run && out_token_kind == mmlex_pkg::KIND_END
      |-> out_token_length == 16'd0)
    else $error("end token with nonzero length");

endmodule
